// ----- design/rmb_pkg.sv -----
`default_nettype none
package rmb_pkg;

	// Fraction bits of unit values (Q2.14).
	localparam int UNIT_FRAC_BITS = 14;

	localparam int UNIT_W = 16;
	localparam int POS_W  = 24;
	localparam int ENT_W  = 32;
	localparam int ACC_W  = 72;

	// Square root of a 32-bit radicand, two iterations per stage.
	localparam int SQ_W        = 32;
	localparam int ROOT_W      = 16;
	localparam int SQ_ITERS    = 16;
	localparam int SQ_PER_ST   = 2;
	localparam int SQ_STAGES   = SQ_ITERS / SQ_PER_ST;
	localparam int SQ_TOP_BIT  = 2 * SQ_ITERS - 2;

	// Restoring divider for the axis ratios, three quotient bits per stage.
	localparam int DIV_W       = 32;
	localparam int QUO_W       = UNIT_FRAC_BITS + 1;
	localparam int DIV_PER_ST  = 3;
	localparam int DIV_STAGES  = QUO_W / DIV_PER_ST;

	// Squares, sum, root stages, numerator, divide stages, sign fix.
	localparam int FRONT_LAT = 2 + SQ_STAGES + 1 + DIV_STAGES + 1;
	localparam int MM_LAT    = 2;
	localparam int TOTAL_LAT = FRONT_LAT + 4 * MM_LAT + 2;

	localparam int IN_DATA_W  = 5 * UNIT_W + 3 * POS_W;
	localparam int OUT_DATA_W = 9 * UNIT_W + 3 * POS_W;

	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [ENT_W-1:0]  ent_t;
	typedef logic [ROOT_W-1:0]        root_t;
	typedef ent_t [2:0][2:0]          mat_t;

	typedef struct packed {
		root_t d;
		unit_t sx;
		unit_t cx;
	} frame_t;

	localparam unit_t UNIT_ONE = UNIT_W'(1 << UNIT_FRAC_BITS);
	localparam ent_t  ENT_ONE  = ENT_W'(1 << UNIT_FRAC_BITS);
	localparam ent_t  ENT_LIM  = ENT_W'(1 << 30);

	localparam logic signed [ACC_W-1:0] ACC_ENT_HI = ACC_W'(1 << 30);
	localparam logic signed [ACC_W-1:0] ACC_ENT_LO = -ACC_ENT_HI;
	localparam logic signed [ACC_W-1:0] ACC_POS_HI = ACC_W'((1 << (POS_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] ACC_POS_LO = -ACC_POS_HI - ACC_W'(1);
	localparam ent_t UNIT_HI = ENT_W'((1 << (UNIT_W - 1)) - 1);
	localparam ent_t UNIT_LO = -UNIT_HI - ENT_W'(1);

	// Shift right by the unit fraction, rounding half away from zero.
	function automatic logic signed [ACC_W-1:0] rshift_round(
		input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = v + ACC_W'(1 << (UNIT_FRAC_BITS - 1)) - ACC_W'(v[ACC_W-1]);
		return t >>> UNIT_FRAC_BITS;
	endfunction

	function automatic ent_t clamp_ent(input logic signed [ACC_W-1:0] v);
		ent_t r;
		if (v > ACC_ENT_HI) begin
			r = ENT_LIM;
		end else if (v < ACC_ENT_LO) begin
			r = -ENT_LIM;
		end else begin
			r = v[ENT_W-1:0];
		end
		return r;
	endfunction

	function automatic unit_t sat_unit(input ent_t v);
		unit_t r;
		if (v > UNIT_HI) begin
			r = UNIT_HI[UNIT_W-1:0];
		end else if (v < UNIT_LO) begin
			r = UNIT_LO[UNIT_W-1:0];
		end else begin
			r = v[UNIT_W-1:0];
		end
		return r;
	endfunction

	function automatic pos_t sat_pos(input logic signed [ACC_W-1:0] v);
		pos_t r;
		if (v > ACC_POS_HI) begin
			r = ACC_POS_HI[POS_W-1:0];
		end else if (v < ACC_POS_LO) begin
			r = ACC_POS_LO[POS_W-1:0];
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/rmb_front.sv -----
`default_nettype none
// Works out d = isqrt(ay^2 + az^2) and the rounded ratios ay/d and az/d.
module rmb_front (
	input  logic             clk,
	input  logic             en,
	input  rmb_pkg::unit_t   ay,
	input  rmb_pkg::unit_t   az,
	output rmb_pkg::frame_t  frame
);

	typedef struct packed {
		logic [rmb_pkg::UNIT_W-1:0] mag_y;
		logic [rmb_pkg::UNIT_W-1:0] mag_z;
		logic                       neg_y;
		logic                       neg_z;
	} sgn_t;

	typedef struct packed {
		logic [rmb_pkg::SQ_W-1:0] rem;
		logic [rmb_pkg::SQ_W-1:0] root;
	} sq_st_t;

	typedef struct packed {
		logic [rmb_pkg::DIV_W-1:0] rem_y;
		logic [rmb_pkg::DIV_W-1:0] rem_z;
		logic [rmb_pkg::QUO_W-1:0] q_y;
		logic [rmb_pkg::QUO_W-1:0] q_z;
		rmb_pkg::root_t            d;
		sgn_t                      sg;
	} dv_st_t;

	function automatic sq_st_t sq_step(input sq_st_t a, input int n);
		sq_st_t o;
		logic [rmb_pkg::SQ_W-1:0] b;
		b = rmb_pkg::SQ_W'(1) << (rmb_pkg::SQ_TOP_BIT - 2 * n);
		if (a.rem >= a.root + b) begin
			o.rem  = a.rem - (a.root + b);
			o.root = (a.root >> 1) + b;
		end else begin
			o.rem  = a.rem;
			o.root = a.root >> 1;
		end
		return o;
	endfunction

	function automatic dv_st_t dv_step(input dv_st_t a, input int i);
		dv_st_t o;
		logic [rmb_pkg::DIV_W-1:0] t;
		o = a;
		t = rmb_pkg::DIV_W'(a.d) << i;
		if (a.rem_y >= t) begin
			o.rem_y  = a.rem_y - t;
			o.q_y[i] = 1'b1;
		end
		if (a.rem_z >= t) begin
			o.rem_z  = a.rem_z - t;
			o.q_z[i] = 1'b1;
		end
		return o;
	endfunction

	logic [rmb_pkg::SQ_W-1:0] sq_y_s1, sq_z_s1, rad_s2;
	sgn_t                     sg_s1, sg_s2;
	sq_st_t                   sq_s   [rmb_pkg::SQ_STAGES];
	sgn_t                     sq_sg_s[rmb_pkg::SQ_STAGES];
	dv_st_t                   num_s;
	dv_st_t                   dv_s   [rmb_pkg::DIV_STAGES];
	rmb_pkg::frame_t          frame_s;
	sgn_t                     sg_in;

	always_comb begin
		sg_in.neg_y = ay[rmb_pkg::UNIT_W-1];
		sg_in.neg_z = az[rmb_pkg::UNIT_W-1];
		sg_in.mag_y = ay[rmb_pkg::UNIT_W-1] ? rmb_pkg::UNIT_W'(-ay) : rmb_pkg::UNIT_W'(ay);
		sg_in.mag_z = az[rmb_pkg::UNIT_W-1] ? rmb_pkg::UNIT_W'(-az) : rmb_pkg::UNIT_W'(az);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_y_s1 <= rmb_pkg::SQ_W'(sg_in.mag_y) * rmb_pkg::SQ_W'(sg_in.mag_y);
			sq_z_s1 <= rmb_pkg::SQ_W'(sg_in.mag_z) * rmb_pkg::SQ_W'(sg_in.mag_z);
			sg_s1   <= sg_in;
			rad_s2  <= sq_y_s1 + sq_z_s1;
			sg_s2   <= sg_s1;
		end
	end

	for (genvar g = 0; g < rmb_pkg::SQ_STAGES; g++) begin : g_sq
		sq_st_t sq_in;
		sgn_t   sg_prev;
		if (g == 0) begin : g_first
			assign sq_in   = '{rem: rad_s2, root: '0};
			assign sg_prev = sg_s2;
		end else begin : g_next
			assign sq_in   = sq_s[g-1];
			assign sg_prev = sq_sg_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[g]    <= sq_step(sq_step(sq_in, rmb_pkg::SQ_PER_ST * g),
					rmb_pkg::SQ_PER_ST * g + 1);
				sq_sg_s[g] <= sg_prev;
			end
		end
	end

	// Numerators (|a| << U) + d/2 for the rounded divide.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s.d     <= sq_s[rmb_pkg::SQ_STAGES-1].root[rmb_pkg::ROOT_W-1:0];
			num_s.sg    <= sq_sg_s[rmb_pkg::SQ_STAGES-1];
			num_s.q_y   <= '0;
			num_s.q_z   <= '0;
			num_s.rem_y <= (rmb_pkg::DIV_W'(sq_sg_s[rmb_pkg::SQ_STAGES-1].mag_y)
				<< rmb_pkg::UNIT_FRAC_BITS)
				+ rmb_pkg::DIV_W'(sq_s[rmb_pkg::SQ_STAGES-1].root[rmb_pkg::ROOT_W-1:1]);
			num_s.rem_z <= (rmb_pkg::DIV_W'(sq_sg_s[rmb_pkg::SQ_STAGES-1].mag_z)
				<< rmb_pkg::UNIT_FRAC_BITS)
				+ rmb_pkg::DIV_W'(sq_s[rmb_pkg::SQ_STAGES-1].root[rmb_pkg::ROOT_W-1:1]);
		end
	end

	for (genvar g = 0; g < rmb_pkg::DIV_STAGES; g++) begin : g_dv
		dv_st_t dv_in;
		if (g == 0) begin : g_first
			assign dv_in = num_s;
		end else begin : g_next
			assign dv_in = dv_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[g] <= dv_step(dv_step(dv_step(dv_in,
					rmb_pkg::QUO_W - 1 - rmb_pkg::DIV_PER_ST * g),
					rmb_pkg::QUO_W - 2 - rmb_pkg::DIV_PER_ST * g),
					rmb_pkg::QUO_W - 3 - rmb_pkg::DIV_PER_ST * g);
			end
		end
	end

	// A zero d means the axis lies on x; Rx then falls back to identity.
	always_ff @(posedge clk) begin
		if (en) begin
			frame_s.d <= dv_s[rmb_pkg::DIV_STAGES-1].d;
			if (dv_s[rmb_pkg::DIV_STAGES-1].d == '0) begin
				frame_s.sx <= '0;
				frame_s.cx <= rmb_pkg::UNIT_ONE;
			end else begin
				frame_s.sx <= dv_s[rmb_pkg::DIV_STAGES-1].sg.neg_y
					? -rmb_pkg::UNIT_W'(dv_s[rmb_pkg::DIV_STAGES-1].q_y)
					:  rmb_pkg::UNIT_W'(dv_s[rmb_pkg::DIV_STAGES-1].q_y);
				frame_s.cx <= dv_s[rmb_pkg::DIV_STAGES-1].sg.neg_z
					? -rmb_pkg::UNIT_W'(dv_s[rmb_pkg::DIV_STAGES-1].q_z)
					:  rmb_pkg::UNIT_W'(dv_s[rmb_pkg::DIV_STAGES-1].q_z);
			end
		end
	end

	assign frame = frame_s;

endmodule
`default_nettype wire

// ----- design/rmb_mat_mul.sv -----
`default_nettype none
// 3x3 product: products in the first stage, rounded and clamped sums in the second.
module rmb_mat_mul (
	input  logic           clk,
	input  logic           en,
	input  rmb_pkg::mat_t  a,
	input  rmb_pkg::mat_t  b,
	output rmb_pkg::mat_t  c
);

	logic signed [2*rmb_pkg::ENT_W-1:0] prod_s1 [3][3][3];
	rmb_pkg::mat_t                      c_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						prod_s1[i][j][k] <= $signed(a[i][k]) * $signed(b[k][j]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					c_s2[i][j] <= rmb_pkg::clamp_ent(rmb_pkg::rshift_round(
						rmb_pkg::ACC_W'(prod_s1[i][j][0])
						+ rmb_pkg::ACC_W'(prod_s1[i][j][1])
						+ rmb_pkg::ACC_W'(prod_s1[i][j][2])));
				end
			end
		end
	end

	assign c = c_s2;

endmodule
`default_nettype wire

// ----- design/axis_rotation_matrix_builder_core.sv -----
`default_nettype none
// Rotation about an arbitrary axis through a pivot point, as an affine matrix.
//
// The slave channel takes one transfer per transform: a unit axis, the cosine
// and sine of the angle (all Q2.14) and the pivot point (Q12.12). The master
// channel returns one transfer per input: the nine 3x3 rotation entries in
// column-major order, saturated to Q2.14, and the translation pivot - R*pivot,
// saturated to Q12.12.
//
// The pipeline is 27 register stages deep. A new transfer is taken every cycle
// as long as the receiver does not stall.
// The depth is set by the squares and their sum (two stages), the square root
// (eight stages), the divide numerators (one stage), the rounded divide for the
// axis ratios (five stages), the sign fix (one stage), the four chained 3x3
// products (two stages each) and the translation (two stages).
//
// Reset clears every valid bit, so the block comes out of reset empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated, and the pipeline moves again in
// the cycle m_tready returns.
module axis_rotation_matrix_builder_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// axis_x, axis_y, axis_z, cos_angle, sin_angle, pivot_x, pivot_y, pivot_z
	input  logic [rmb_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_c0_r0, m_c0_r1, m_c0_r2, m_c1_r0 .. m_c2_r2, shift_x, shift_y, shift_z
	output logic [rmb_pkg::OUT_DATA_W-1:0]     m_tdata
);

	localparam int SIDE_N  = rmb_pkg::FRONT_LAT + 4 * rmb_pkg::MM_LAT;
	localparam int FRAME_N = 3 * rmb_pkg::MM_LAT;
	localparam int I_MM1   = rmb_pkg::FRONT_LAT - 1;
	localparam int I_MM2   = rmb_pkg::FRONT_LAT + rmb_pkg::MM_LAT - 1;
	localparam int I_MM3   = rmb_pkg::FRONT_LAT + 2 * rmb_pkg::MM_LAT - 1;

	typedef struct packed {
		rmb_pkg::unit_t ax;
		rmb_pkg::unit_t c;
		rmb_pkg::unit_t s;
		rmb_pkg::pos_t  px;
		rmb_pkg::pos_t  py;
		rmb_pkg::pos_t  pz;
	} side_t;

	logic                         en;
	logic [rmb_pkg::TOTAL_LAT-1:0] vld_q;
	side_t                        side_in;
	side_t                        side_q  [SIDE_N];
	rmb_pkg::frame_t              frame_out;
	rmb_pkg::frame_t              frame_q [FRAME_N];
	rmb_pkg::mat_t                rx, ry, rz, ryi, rxi;
	rmb_pkg::mat_t                ma, mb, mc, mr;
	rmb_pkg::pos_t                piv     [3];

	logic signed [rmb_pkg::ENT_W+rmb_pkg::POS_W-1:0] tprod_s1 [3][3];
	rmb_pkg::pos_t                                   piv_s1   [3];
	rmb_pkg::mat_t                                   r_s1;
	logic [rmb_pkg::OUT_DATA_W-1:0]                  out_data_s2;

	// The pipeline advances unless the output register holds an untaken result.
	assign en       = !vld_q[rmb_pkg::TOTAL_LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[rmb_pkg::TOTAL_LAT-1];
	assign m_tdata  = out_data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[rmb_pkg::TOTAL_LAT-2:0], s_tvalid};
		end
	end

	// Unpack the input transfer; fields sit from the lowest bit up.
	always_comb begin
		side_in.ax = s_tdata[0 +: rmb_pkg::UNIT_W];
		side_in.c  = s_tdata[3*rmb_pkg::UNIT_W +: rmb_pkg::UNIT_W];
		side_in.s  = s_tdata[4*rmb_pkg::UNIT_W +: rmb_pkg::UNIT_W];
		side_in.px = s_tdata[5*rmb_pkg::UNIT_W +: rmb_pkg::POS_W];
		side_in.py = s_tdata[5*rmb_pkg::UNIT_W + rmb_pkg::POS_W +: rmb_pkg::POS_W];
		side_in.pz = s_tdata[5*rmb_pkg::UNIT_W + 2*rmb_pkg::POS_W +: rmb_pkg::POS_W];
	end

	// Fields not needed by the front end ride along in a delay line so that
	// each matrix product sees them in step with its own operands.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int k = 1; k < SIDE_N; k++) begin
				side_q[k] <= side_q[k-1];
			end
			frame_q[0] <= frame_out;
			for (int k = 1; k < FRAME_N; k++) begin
				frame_q[k] <= frame_q[k-1];
			end
		end
	end

	rmb_front u_front (
		.clk   (clk),
		.en    (en),
		.ay    (s_tdata[rmb_pkg::UNIT_W +: rmb_pkg::UNIT_W]),
		.az    (s_tdata[2*rmb_pkg::UNIT_W +: rmb_pkg::UNIT_W]),
		.frame (frame_out)
	);

	// Elementary rotations. Rx uses the ratios, Ry uses d and the axis x
	// component, Rz uses the angle; the inverses are the transposes.
	always_comb begin
		rx = '0;
		rx[0][0] = rmb_pkg::ENT_ONE;
		rx[1][1] = rmb_pkg::ent_t'(frame_out.cx);
		rx[1][2] = -rmb_pkg::ent_t'(frame_out.sx);
		rx[2][1] = rmb_pkg::ent_t'(frame_out.sx);
		rx[2][2] = rmb_pkg::ent_t'(frame_out.cx);

		ry = '0;
		ry[0][0] = rmb_pkg::ENT_W'(frame_out.d);
		ry[0][2] = -rmb_pkg::ent_t'(side_q[I_MM1].ax);
		ry[1][1] = rmb_pkg::ENT_ONE;
		ry[2][0] = rmb_pkg::ent_t'(side_q[I_MM1].ax);
		ry[2][2] = rmb_pkg::ENT_W'(frame_out.d);

		rz = '0;
		rz[0][0] = rmb_pkg::ent_t'(side_q[I_MM2].c);
		rz[0][1] = -rmb_pkg::ent_t'(side_q[I_MM2].s);
		rz[1][0] = rmb_pkg::ent_t'(side_q[I_MM2].s);
		rz[1][1] = rmb_pkg::ent_t'(side_q[I_MM2].c);
		rz[2][2] = rmb_pkg::ENT_ONE;

		ryi = '0;
		ryi[0][0] = rmb_pkg::ENT_W'(frame_q[2*rmb_pkg::MM_LAT-1].d);
		ryi[0][2] = rmb_pkg::ent_t'(side_q[I_MM3].ax);
		ryi[1][1] = rmb_pkg::ENT_ONE;
		ryi[2][0] = -rmb_pkg::ent_t'(side_q[I_MM3].ax);
		ryi[2][2] = rmb_pkg::ENT_W'(frame_q[2*rmb_pkg::MM_LAT-1].d);

		rxi = '0;
		rxi[0][0] = rmb_pkg::ENT_ONE;
		rxi[1][1] = rmb_pkg::ent_t'(frame_q[FRAME_N-1].cx);
		rxi[1][2] = rmb_pkg::ent_t'(frame_q[FRAME_N-1].sx);
		rxi[2][1] = -rmb_pkg::ent_t'(frame_q[FRAME_N-1].sx);
		rxi[2][2] = rmb_pkg::ent_t'(frame_q[FRAME_N-1].cx);
	end

	// R = RxInv * RyInv * Rz * Ry * Rx, multiplied from the right.
	rmb_mat_mul u_mm_a (.clk(clk), .en(en), .a(ry),  .b(rx), .c(ma));
	rmb_mat_mul u_mm_b (.clk(clk), .en(en), .a(rz),  .b(ma), .c(mb));
	rmb_mat_mul u_mm_c (.clk(clk), .en(en), .a(ryi), .b(mb), .c(mc));
	rmb_mat_mul u_mm_r (.clk(clk), .en(en), .a(rxi), .b(mc), .c(mr));

	always_comb begin
		piv[0] = side_q[SIDE_N-1].px;
		piv[1] = side_q[SIDE_N-1].py;
		piv[2] = side_q[SIDE_N-1].pz;
	end

	// Translation, first stage: the nine products R[i][j] * pivot[j].
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					tprod_s1[i][j] <= $signed(mr[i][j]) * $signed(piv[j]);
				end
				piv_s1[i] <= piv[i];
			end
			r_s1 <= mr;
		end
	end

	// Second stage: pivot scaled to the product format minus R*pivot, rounded
	// back to the position format and saturated; entries saturate to 16 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					out_data_s2[(j*3 + i)*rmb_pkg::UNIT_W +: rmb_pkg::UNIT_W] <=
						rmb_pkg::sat_unit(r_s1[i][j]);
				end
			end
			for (int i = 0; i < 3; i++) begin
				out_data_s2[9*rmb_pkg::UNIT_W + i*rmb_pkg::POS_W +: rmb_pkg::POS_W] <=
					rmb_pkg::sat_pos(rmb_pkg::rshift_round(
						(rmb_pkg::ACC_W'(piv_s1[i]) <<< rmb_pkg::UNIT_FRAC_BITS)
						- rmb_pkg::ACC_W'(tprod_s1[i][0])
						- rmb_pkg::ACC_W'(tprod_s1[i][1])
						- rmb_pkg::ACC_W'(tprod_s1[i][2])));
			end
		end
	end

	// An accepted transfer enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted transfer did not enter the pipeline");

	// While input is refused the pipeline must hold every valid bit.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

	// An axis along x must give the identity Rx.
	a_x_axis_identity: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[I_MM1] && frame_out.d == '0 |->
		frame_out.sx == '0 && frame_out.cx == rmb_pkg::UNIT_ONE)
		else $error("zero d without identity Rx");

endmodule
`default_nettype wire

// ----- verif/axis_rotation_matrix_builder_core_tb.sv -----
`default_nettype none
module axis_rotation_matrix_builder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int U = rmb_pkg::UNIT_FRAC_BITS;
	localparam int ITEMS = 1000;
	localparam int DRAIN_CYCLES = rmb_pkg::TOTAL_LAT + 10;

	typedef struct packed {
		rmb_pkg::pos_t  pz;
		rmb_pkg::pos_t  py;
		rmb_pkg::pos_t  px;
		rmb_pkg::unit_t sn;
		rmb_pkg::unit_t cs;
		rmb_pkg::unit_t az;
		rmb_pkg::unit_t ay;
		rmb_pkg::unit_t ax;
	} xform_req_t;

	typedef logic [rmb_pkg::OUT_DATA_W-1:0] affine_word_t;
	typedef longint mat9_t [3][3];

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [rmb_pkg::IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [rmb_pkg::OUT_DATA_W-1:0] m_tdata;

	// Requests waiting for the driver, and the affine words the block owes us.
	xform_req_t   req_queue[$];
	affine_word_t affine_expected[$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;

	axis_rotation_matrix_builder_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Shift right by U with rounding half away from zero.
	function automatic longint round_shift(input longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (U - 1))) >>> U;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint limit(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Integer square root, bit by bit from the top pair down.
	function automatic longint int_sqrt(input longint x);
		longint r;
		longint b;
		r = 0;
		b = longint'(1) << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint ratio_of(input longint a, input longint d);
		longint mag;
		longint q;
		mag = (a < 0) ? -a : a;
		q = ((mag << U) + (d >> 1)) / d;
		return (a < 0) ? -q : q;
	endfunction

	function automatic mat9_t mat_product(input mat9_t a, input mat9_t b);
		mat9_t o;
		longint acc;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
				o[i][j] = limit(round_shift(acc), -(longint'(1) << 30), longint'(1) << 30);
			end
		end
		return o;
	endfunction

	function automatic mat9_t unit_matrix();
		mat9_t m;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? (longint'(1) << U) : 0;
		return m;
	endfunction

	// Builds the expected affine word for one request.
	function automatic affine_word_t affine_of(input xform_req_t q);
		longint one;
		longint ax, ay, az, c, s, d, sx, cx, acc;
		longint p[3];
		mat9_t rx, rxi, ry, ryi, rz, r;
		affine_word_t w;
		one = longint'(1) << U;
		ax = q.ax; ay = q.ay; az = q.az; c = q.cs; s = q.sn;
		p[0] = q.px; p[1] = q.py; p[2] = q.pz;
		d = int_sqrt(ay * ay + az * az);
		sx = 0;
		cx = one;
		// An axis along x leaves Rx as the identity.
		if (d != 0) begin
			sx = ratio_of(ay, d);
			cx = ratio_of(az, d);
		end
		rx = unit_matrix();
		rx[1][1] = cx; rx[1][2] = -sx; rx[2][1] = sx; rx[2][2] = cx;
		rxi = unit_matrix();
		rxi[1][1] = cx; rxi[1][2] = sx; rxi[2][1] = -sx; rxi[2][2] = cx;
		ry = unit_matrix();
		ry[0][0] = d; ry[0][2] = -ax; ry[2][0] = ax; ry[2][2] = d;
		ryi = unit_matrix();
		ryi[0][0] = d; ryi[0][2] = ax; ryi[2][0] = -ax; ryi[2][2] = d;
		rz = unit_matrix();
		rz[0][0] = c; rz[0][1] = -s; rz[1][0] = s; rz[1][1] = c;
		r = mat_product(rxi, mat_product(ryi, mat_product(rz, mat_product(ry, rx))));
		w = '0;
		for (int j = 0; j < 3; j++)
			for (int i = 0; i < 3; i++)
				w[(j * 3 + i) * rmb_pkg::UNIT_W +: rmb_pkg::UNIT_W] =
					rmb_pkg::UNIT_W'(limit(r[i][j], -32768, 32767));
		for (int i = 0; i < 3; i++) begin
			acc = p[i] * one;
			for (int j = 0; j < 3; j++) acc -= r[i][j] * p[j];
			w[9 * rmb_pkg::UNIT_W + i * rmb_pkg::POS_W +: rmb_pkg::POS_W] =
				rmb_pkg::POS_W'(limit(round_shift(acc), -8388608, 8388607));
		end
		return w;
	endfunction

	// Driver: offers the head of the request queue, idling at random. The
	// expectation is recorded at the transfer edge itself, and the accepted
	// request leaves the queue there, so the next one is always at the head.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				affine_expected.push_back(affine_of(xform_req_t'(s_tdata)));
				void'(req_queue.pop_front());
			end
			if (!(s_tvalid && !s_tready)) begin
				if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= req_queue[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each output transfer against the oldest expectation
	// and stalls the receiver at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (affine_expected.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected output transfer: %h", m_tdata);
				end else begin
					affine_word_t e;
					e = affine_expected.pop_front();
					for (int f = 0; f < 12; f++) begin
						int lsb, wd;
						lsb = (f < 9) ? f * rmb_pkg::UNIT_W
							: 9 * rmb_pkg::UNIT_W + (f - 9) * rmb_pkg::POS_W;
						wd = (f < 9) ? rmb_pkg::UNIT_W : rmb_pkg::POS_W;
						if (((e ^ m_tdata) >> lsb) & ((affine_word_t'(1) << wd) - 1)) begin
							mismatch_count++;
							if (mismatch_count <= 10)
								$display("field %0d mismatch: expected %h actual %h", f,
									(e >> lsb) & ((affine_word_t'(1) << wd) - 1),
									(m_tdata >> lsb) & ((affine_word_t'(1) << wd) - 1));
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic xform_req_t random_req();
		xform_req_t q;
		int mode;
		q = xform_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		mode = $urandom_range(9);
		if (mode < 7) begin
			// Mostly near-unit axes and angles; the pivots keep their full random range.
			q.ax = rmb_pkg::unit_t'($signed($urandom_range(32768)) - 16384);
			q.ay = rmb_pkg::unit_t'($signed($urandom_range(32768)) - 16384);
			q.az = rmb_pkg::unit_t'($signed($urandom_range(32768)) - 16384);
			q.cs = rmb_pkg::unit_t'($signed($urandom_range(32768)) - 16384);
			q.sn = rmb_pkg::unit_t'($signed($urandom_range(32768)) - 16384);
			if (mode == 0) begin
				q.ay = '0;
				q.az = '0;
			end
		end
		return q;
	endfunction

	function automatic xform_req_t mk(input rmb_pkg::unit_t ax, ay, az, cs, sn,
		input rmb_pkg::pos_t p);
		xform_req_t q;
		q.ax = ax; q.ay = ay; q.az = az; q.cs = cs; q.sn = sn;
		q.px = p; q.py = -p; q.pz = p >>> 1;
		return q;
	endfunction

	task automatic wait_drained();
		while (req_queue.size() != 0 || s_tvalid || affine_expected.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		phase_idle = '{0, 69, 0, 20};
		phase_stall = '{0, 0, 69, 20};
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// Directed part: identity rotation, axes along each direction, the
		// axis along x where Rx stays identity, and full-scale extremes.
		req_queue.push_back(mk(16384, 0, 0, 16384, 0, 0));
		req_queue.push_back(mk(16384, 0, 0, 0, 16384, 24'sd4096));
		req_queue.push_back(mk(-16384, 0, 0, 0, -16384, 24'sd8388607));
		req_queue.push_back(mk(0, 16384, 0, 11585, 11585, 24'sd40960));
		req_queue.push_back(mk(0, 0, 16384, -16384, 0, -24'sd8388608));
		req_queue.push_back(mk(9459, 9459, 9459, 8192, 14189, 24'sd123456));
		req_queue.push_back(mk(32767, 32767, 32767, 32767, 32767, 24'sd8388607));
		req_queue.push_back(mk(-32768, -32768, -32768, -32768, -32768, -24'sd8388608));
		req_queue.push_back(mk(0, 0, 0, 0, 0, 0));
		req_queue.push_back(mk(0, -32768, 1, 32767, -32768, 24'sd1));
		req_queue.push_back(mk(1, 0, -1, -1, 1, -24'sd1));
		req_queue.push_back(mk(-16384, 0, 0, 32767, 32767, 24'sd8388607));
		wait_drained();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_idle[ph];
			recv_stall_pct = phase_stall[ph];
			for (int n = 0; n < ITEMS / 4; n++) begin
				req_queue.push_back(random_req());
				if (n == ITEMS / 8) wait_drained();
				while (req_queue.size() > 8) @(posedge clk);
			end
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && affine_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
